// ===== src/tlq_pkg.sv =====
// Package for the four-level trap queue: item types, command and status codes.
// Used by tlq_ctrl, tlq_store and four_level_trap_queue_core; depends on nothing.
package tlq_pkg;

    localparam int NUM_MODES = 4;
    localparam int MODE_W    = 2;
    localparam int QUOTA_W   = 5;
    localparam int STATUS_W  = 3;

    localparam logic [QUOTA_W-1:0] QUOTA_RESET = 5'd16;

    localparam logic [1:0] CMD_DECLARE = 2'd0;
    localparam logic [1:0] CMD_SET_EN  = 2'd1;
    localparam logic [1:0] CMD_DELIVER = 2'd2;
    localparam logic [1:0] CMD_FLUSH   = 2'd3;

    localparam logic [MODE_W-1:0] MODE_KERNEL = 2'd0;

    localparam logic [STATUS_W-1:0] ST_NORMAL    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PARAM = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PRIV   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_QUOTA     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WAS_SET   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_WAS_CLEAR = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd6;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  caller_mode;
        logic [1:0]  privilege_bits;
        logic [2:0]  target_mode;
        logic [63:0] handler_address;
        logic [63:0] handler_param;
        logic        enable_request;
        logic [1:0]  flush_from_mode;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] out_handler_address;
        logic [63:0] out_handler_param;
        logic [1:0]  delivered_mode;
        logic        previous_enable;
    } t_out_item;

    typedef struct packed {
        logic [63:0] handler_address;
        logic [63:0] handler_param;
    } t_entry;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MODE_W-1:0]   mode;
        logic                prev_en;
        logic                hit;
    } t_res_meta;

endpackage

// ===== src/tlq_store.sv =====
// Trap entry memory: one write and one read per cycle, read data registered.
// Depends on tlq_pkg for the entry type and the memory command struct.
module tlq_store #(
    parameter int ADDR_W = 6
) (
    input  logic                  i_clk,
    input  tlq_pkg::t_mem_cmd     i_cmd,
    input  logic [ADDR_W-1:0]     i_addr,
    input  tlq_pkg::t_entry       i_wdata,
    output tlq_pkg::t_entry       o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    tlq_pkg::t_entry r_mem [0:DEPTH-1];
    tlq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tlq_ctrl.sv =====
// Queue control: per-mode pointers, counts, enables and the quota register.
// Decides each command's result and drives the entry memory; depends on tlq_pkg.
module tlq_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PTR_W       = 4,
    parameter int ADDR_W      = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  tlq_pkg::t_in_item              i_item,
    input  logic                           i_cfg_we,
    input  logic [tlq_pkg::QUOTA_W-1:0]    i_cfg_wdata,
    output tlq_pkg::t_res_meta             o_meta,
    output tlq_pkg::t_mem_cmd              o_mem_cmd,
    output logic [ADDR_W-1:0]              o_mem_addr
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > tlq_pkg::QUOTA_W) ? CNT_W : tlq_pkg::QUOTA_W;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(QUEUE_DEPTH);

    logic [PTR_W-1:0]            r_head  [tlq_pkg::NUM_MODES];
    logic [PTR_W-1:0]            r_tail  [tlq_pkg::NUM_MODES];
    logic [CNT_W-1:0]            r_count [tlq_pkg::NUM_MODES];
    logic [tlq_pkg::NUM_MODES-1:0] r_en;
    logic [tlq_pkg::QUOTA_W-1:0] r_quota;

    logic [tlq_pkg::MODE_W-1:0]  w_cur;
    logic [tlq_pkg::MODE_W-1:0]  w_tgt;
    logic [CMP_W-1:0]            w_quota_ext;
    logic [CMP_W-1:0]            w_limit;
    logic                        w_bad;
    logic                        w_no_priv;
    logic                        w_full;
    logic                        w_hit;
    logic [tlq_pkg::MODE_W-1:0]  w_sel;
    logic [tlq_pkg::MODE_W-1:0]  w_mi;
    logic                        w_decl_ok;
    logic [PTR_W-1:0]            w_tail_next;
    logic [PTR_W-1:0]            w_head_next;

    assign w_cur = i_item.caller_mode;
    assign w_tgt = i_item.target_mode[1:0];
    assign w_quota_ext = CMP_W'(r_quota);
    assign w_limit = (w_quota_ext < DEPTH_CMP) ? w_quota_ext : DEPTH_CMP;

    assign w_bad = i_item.target_mode[2] | (i_item.handler_address == 64'd0);
    assign w_no_priv = (w_tgt < w_cur) &&
        (((w_tgt == tlq_pkg::MODE_KERNEL) && !i_item.privilege_bits[0]) ||
         ((w_tgt != tlq_pkg::MODE_KERNEL) && (i_item.privilege_bits == 2'b00)));
    assign w_full = CMP_W'(r_count[w_tgt]) >= w_limit;
    assign w_decl_ok = !w_bad && !w_no_priv && !w_full;

    always_comb begin
        w_hit = 1'b0;
        w_sel = w_cur;
        w_mi  = '0;
        for (int m = tlq_pkg::NUM_MODES - 1; m >= 0; m--) begin
            w_mi = tlq_pkg::MODE_W'(m);
            if ((w_mi >= w_cur) && r_en[w_mi] && (r_count[w_mi] != '0)) begin
                w_hit = 1'b1;
                w_sel = w_mi;
            end
        end
    end

    assign w_tail_next = (r_tail[w_tgt] == LAST_SLOT) ? '0 : r_tail[w_tgt] + 1'b1;
    assign w_head_next = (r_head[w_sel] == LAST_SLOT) ? '0 : r_head[w_sel] + 1'b1;

    always_comb begin
        o_meta = '0;
        unique case (i_item.command)
            tlq_pkg::CMD_DECLARE: begin
                if (w_bad) begin
                    o_meta.status = tlq_pkg::ST_BAD_PARAM;
                end else if (w_no_priv) begin
                    o_meta.status = tlq_pkg::ST_NO_PRIV;
                end else if (w_full) begin
                    o_meta.status = tlq_pkg::ST_QUOTA;
                end else begin
                    o_meta.status = tlq_pkg::ST_NORMAL;
                end
            end
            tlq_pkg::CMD_SET_EN: begin
                o_meta.status  = r_en[w_cur] ? tlq_pkg::ST_WAS_SET : tlq_pkg::ST_WAS_CLEAR;
                o_meta.prev_en = r_en[w_cur];
            end
            tlq_pkg::CMD_DELIVER: begin
                o_meta.status = w_hit ? tlq_pkg::ST_NORMAL : tlq_pkg::ST_NONE;
                o_meta.hit    = w_hit;
                o_meta.mode   = w_hit ? w_sel : '0;
            end
            tlq_pkg::CMD_FLUSH: begin
                o_meta.status = tlq_pkg::ST_NORMAL;
            end
            default: begin
                o_meta.status = tlq_pkg::ST_NORMAL;
            end
        endcase
    end

    assign o_mem_cmd = {
        i_take && (i_item.command == tlq_pkg::CMD_DECLARE) && w_decl_ok,
        i_take && (i_item.command == tlq_pkg::CMD_DELIVER) && w_hit
    };
    assign o_mem_addr = (i_item.command == tlq_pkg::CMD_DECLARE) ?
        {w_tgt, r_tail[w_tgt]} : {w_sel, r_head[w_sel]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < tlq_pkg::NUM_MODES; m++) begin
                r_head[m]  <= '0;
                r_tail[m]  <= '0;
                r_count[m] <= '0;
            end
            r_en    <= '1;
            r_quota <= tlq_pkg::QUOTA_RESET;
        end else begin
            if (i_cfg_we) begin
                r_quota <= i_cfg_wdata;
            end
            if (i_take) begin
                case (i_item.command)
                    tlq_pkg::CMD_DECLARE: begin
                        if (w_decl_ok) begin
                            r_tail[w_tgt]  <= w_tail_next;
                            r_count[w_tgt] <= r_count[w_tgt] + 1'b1;
                        end
                    end
                    tlq_pkg::CMD_SET_EN: begin
                        r_en[w_cur] <= i_item.enable_request;
                    end
                    tlq_pkg::CMD_DELIVER: begin
                        if (w_hit) begin
                            r_head[w_sel]  <= w_head_next;
                            r_count[w_sel] <= r_count[w_sel] - 1'b1;
                        end
                    end
                    default: begin
                        for (int m = 0; m < tlq_pkg::NUM_MODES; m++) begin
                            if (tlq_pkg::MODE_W'(m) >= i_item.flush_from_mode) begin
                                r_head[m]  <= '0;
                                r_tail[m]  <= '0;
                                r_count[m] <= '0;
                            end
                        end
                    end
                endcase
            end
        end
    end

endmodule

// ===== src/four_level_trap_queue_core.sv =====
// Four-level trap queue with per-mode enables: four trap FIFOs in one memory.
// An accepted item's result is held in a pending register, then moves to the output register once it is free.
// The input stalls while a result is pending, waiting on the registered read of the entry memory.
// Reset is synchronous: pointers and counts clear, enables set, quota returns to 16.
// The entry memory is not cleared; only written entries are ever read.
// Depends on tlq_pkg, tlq_ctrl and tlq_store.
module four_level_trap_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  tlq_pkg::t_in_item            i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output tlq_pkg::t_out_item           o_out_item,
    input  logic                         i_cfg_we,
    input  logic [tlq_pkg::QUOTA_W-1:0]  i_cfg_wdata
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ADDR_W = tlq_pkg::MODE_W + PTR_W;

    logic                 w_take;
    logic                 w_out_free;
    tlq_pkg::t_res_meta   w_meta;
    tlq_pkg::t_mem_cmd    w_mem_cmd;
    logic [ADDR_W-1:0]    w_mem_addr;
    tlq_pkg::t_entry      w_wdata;
    tlq_pkg::t_entry      w_rdata;

    logic                 r_pend_valid;
    tlq_pkg::t_res_meta   r_pend;
    logic                 r_out_valid;
    tlq_pkg::t_out_item   r_out;

    assign o_in_stall = r_pend_valid || !i_rst_n;
    assign w_take     = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_wdata = {i_in_item.handler_address, i_in_item.handler_param};

    tlq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_meta      (w_meta),
        .o_mem_cmd   (w_mem_cmd),
        .o_mem_addr  (w_mem_addr)
    );

    tlq_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_cmd   (w_mem_cmd),
        .i_addr  (w_mem_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_take) begin
                r_pend_valid <= 1'b1;
            end else if (r_pend_valid && w_out_free) begin
                r_pend_valid <= 1'b0;
            end
            if (r_pend_valid && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pend <= w_meta;
        end
        if (r_pend_valid && w_out_free) begin
            r_out.status              <= r_pend.status;
            r_out.out_handler_address <= r_pend.hit ? w_rdata.handler_address : 64'd0;
            r_out.out_handler_param   <= r_pend.hit ? w_rdata.handler_param : 64'd0;
            r_out.delivered_mode      <= r_pend.mode;
            r_out.previous_enable     <= r_pend.prev_en;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for four_level_trap_queue_core: directed and random trap commands,
// predicted in-line and compared field by field. Depends on tlq_pkg and the core RTL.
module testbench;

    localparam int          CLK_PERIOD       = 8;
    localparam int          RESET_CYCLES     = 4;
    localparam int          QUEUE_DEPTH      = 16;
    localparam int          WATCHDOG_LIMIT   = 2000;
    localparam int          LONG_HOLD_CYCLES = 200;
    localparam int          MAX_REPORTS      = 10;
    localparam logic [63:0] ALL_ONES         = '1;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    tlq_pkg::t_in_item            i_in_item   = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    tlq_pkg::t_out_item           o_out_item;
    logic                         i_cfg_we    = 1'b0;
    logic [tlq_pkg::QUOTA_W-1:0]  i_cfg_wdata = '0;

    logic [63:0]                  queued_address [tlq_pkg::NUM_MODES*QUEUE_DEPTH];
    logic [63:0]                  queued_param [tlq_pkg::NUM_MODES*QUEUE_DEPTH];
    int unsigned                  head_slot [tlq_pkg::NUM_MODES];
    int unsigned                  tail_slot [tlq_pkg::NUM_MODES];
    int unsigned                  pending_traps [tlq_pkg::NUM_MODES];
    logic                         delivery_enabled [tlq_pkg::NUM_MODES];
    logic [tlq_pkg::QUOTA_W-1:0]  quota_limit;

    tlq_pkg::t_out_item   trap_results_due[$];
    tlq_pkg::t_out_item   due_result;
    int                   mismatch_count      = 0;
    int                   idle_cycles         = 0;
    int unsigned          send_idle_pct       = 0;
    int unsigned          recv_idle_pct       = 0;
    int                   long_hold_requests  = 0;
    int                   long_holds_started  = 0;
    int                   stall_cycles_left   = 0;

    four_level_trap_queue_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    function automatic tlq_pkg::t_out_item predict_trap_op(input tlq_pkg::t_in_item it);
        tlq_pkg::t_out_item res;
        int unsigned        limit;
        int unsigned        slot;
        int unsigned        m;
        logic               found;
        res   = '0;
        found = 1'b0;
        case (it.command)
            tlq_pkg::CMD_DECLARE: begin
                limit = (quota_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : quota_limit;
                if (it.target_mode >= tlq_pkg::NUM_MODES || it.handler_address == '0) begin
                    res.status = tlq_pkg::ST_BAD_PARAM;
                end else if (it.target_mode < it.caller_mode &&
                             ((it.target_mode == tlq_pkg::MODE_KERNEL) ?
                                  !it.privilege_bits[0] : it.privilege_bits == 2'b00)) begin
                    res.status = tlq_pkg::ST_NO_PRIV;
                end else if (pending_traps[it.target_mode] >= limit) begin
                    res.status = tlq_pkg::ST_QUOTA;
                end else begin
                    slot = it.target_mode * QUEUE_DEPTH + tail_slot[it.target_mode];
                    queued_address[slot] = it.handler_address;
                    queued_param[slot]   = it.handler_param;
                    tail_slot[it.target_mode] = (tail_slot[it.target_mode] + 1) % QUEUE_DEPTH;
                    pending_traps[it.target_mode]++;
                    res.status = tlq_pkg::ST_NORMAL;
                end
            end
            tlq_pkg::CMD_SET_EN: begin
                res.previous_enable = delivery_enabled[it.caller_mode];
                res.status = delivery_enabled[it.caller_mode] ? tlq_pkg::ST_WAS_SET
                                                              : tlq_pkg::ST_WAS_CLEAR;
                delivery_enabled[it.caller_mode] = it.enable_request;
            end
            tlq_pkg::CMD_DELIVER: begin
                res.status = tlq_pkg::ST_NONE;
                for (m = it.caller_mode; m < tlq_pkg::NUM_MODES; m++) begin
                    if (!found && delivery_enabled[m] && pending_traps[m] != 0) begin
                        found = 1'b1;
                        slot  = m * QUEUE_DEPTH + head_slot[m];
                        res.status              = tlq_pkg::ST_NORMAL;
                        res.out_handler_address = queued_address[slot];
                        res.out_handler_param   = queued_param[slot];
                        res.delivered_mode      = 2'(m);
                        head_slot[m] = (head_slot[m] + 1) % QUEUE_DEPTH;
                        pending_traps[m]--;
                    end
                end
            end
            default: begin
                for (m = it.flush_from_mode; m < tlq_pkg::NUM_MODES; m++) begin
                    head_slot[m]     = 0;
                    tail_slot[m]     = 0;
                    pending_traps[m] = 0;
                end
                res.status = tlq_pkg::ST_NORMAL;
            end
        endcase
        return res;
    endfunction

    function automatic tlq_pkg::t_in_item trap_op(input logic [1:0] cmd, input logic [1:0] cur,
                                                  input logic [1:0] privs,
                                                  input logic [2:0] target,
                                                  input logic [63:0] addr,
                                                  input logic [63:0] prm,
                                                  input logic en, input logic [1:0] from);
        tlq_pkg::t_in_item it;
        it.command         = cmd;
        it.caller_mode     = cur;
        it.privilege_bits  = privs;
        it.target_mode     = target;
        it.handler_address = addr;
        it.handler_param   = prm;
        it.enable_request  = en;
        it.flush_from_mode = from;
        return it;
    endfunction

    function automatic tlq_pkg::t_in_item random_trap_op(input logic [1:0] focus_mode);
        tlq_pkg::t_in_item it;
        int unsigned       pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            it.command = tlq_pkg::CMD_DECLARE;
        end else if (pick < 80) begin
            it.command = tlq_pkg::CMD_DELIVER;
        end else if (pick < 93) begin
            it.command = tlq_pkg::CMD_SET_EN;
        end else begin
            it.command = tlq_pkg::CMD_FLUSH;
        end
        it.caller_mode    = 2'($urandom_range(3));
        it.privilege_bits = 2'($urandom_range(3));
        if ($urandom_range(19) == 0) begin
            it.target_mode = 3'($urandom_range(7, 4));
        end else if ($urandom_range(1) == 0) begin
            it.target_mode = {1'b0, focus_mode};
        end else begin
            it.target_mode = 3'($urandom_range(3));
        end
        it.handler_address = ($urandom_range(24) == 0) ? 64'd0 : {$urandom, $urandom};
        it.handler_param   = {$urandom, $urandom};
        it.enable_request  = ($urandom_range(9) < 7);
        it.flush_from_mode = 2'($urandom_range(3));
        return it;
    endfunction

    task automatic reset_trap_model();
        for (int m = 0; m < tlq_pkg::NUM_MODES; m++) begin
            head_slot[m]        = 0;
            tail_slot[m]        = 0;
            pending_traps[m]    = 0;
            delivery_enabled[m] = 1'b1;
        end
        quota_limit = tlq_pkg::QUOTA_RESET;
    endtask

    task automatic send_item(input tlq_pkg::t_in_item it);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        trap_results_due.push_back(predict_trap_op(it));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (trap_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_quota(input logic [tlq_pkg::QUOTA_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        quota_limit = value;
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("Mismatch in %s: expected %h, got %h", field, want, got);
        end
    endtask

    task automatic test_declare_checks();
        send_item(trap_op(tlq_pkg::CMD_DECLARE, 2'd3, 2'd3, 3'd7, 64'h10, 64'h1, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_DECLARE, 2'd0, 2'd3, 3'd4, 64'h20, 64'h2, 1'b1, 2'd1));
        send_item(trap_op(tlq_pkg::CMD_DECLARE, 2'd0, 2'd3, 3'd3, 64'd0, ALL_ONES, 1'b0, 2'd2));
        send_item(trap_op(tlq_pkg::CMD_DECLARE, 2'd3, 2'd0, 3'd0, 64'h30, 64'h3, 1'b1, 2'd3));
        send_item(trap_op(tlq_pkg::CMD_DECLARE, 2'd3, 2'd2, 3'd0, 64'h40, 64'h4, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_DECLARE, 2'd3, 2'd1, 3'd0, ALL_ONES, ALL_ONES, 1'b1,
                          2'd3));
        send_item(trap_op(tlq_pkg::CMD_DECLARE, 2'd2, 2'd0, 3'd1, 64'h50, 64'h5, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_DECLARE, 2'd2, 2'd2, 3'd1, 64'h60, 64'h6, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_DECLARE, 2'd1, 2'd0, 3'd1, 64'h70, 64'h7, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_DECLARE, 2'd0, 2'd0, 3'd3, 64'd1, 64'd0, 1'b0, 2'd0));
    endtask

    task automatic test_enables_and_delivery();
        send_item(trap_op(tlq_pkg::CMD_DELIVER, 2'd0, 2'd0, 3'd0, 64'd0, 64'd0, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_SET_EN, 2'd1, 2'd0, 3'd0, 64'd0, 64'd0, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_SET_EN, 2'd1, 2'd3, 3'd7, ALL_ONES, ALL_ONES, 1'b0,
                          2'd3));
        send_item(trap_op(tlq_pkg::CMD_DELIVER, 2'd1, 2'd0, 3'd0, 64'd0, 64'd0, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_DELIVER, 2'd3, 2'd0, 3'd0, 64'd0, 64'd0, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_SET_EN, 2'd1, 2'd0, 3'd0, 64'd0, 64'd0, 1'b1, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_DELIVER, 2'd1, 2'd0, 3'd0, 64'd0, 64'd0, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_DELIVER, 2'd2, 2'd0, 3'd0, 64'd0, 64'd0, 1'b0, 2'd0));
    endtask

    task automatic test_flush();
        send_item(trap_op(tlq_pkg::CMD_DECLARE, 2'd0, 2'd0, 3'd2, 64'h80, 64'h8, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_FLUSH, 2'd0, 2'd0, 3'd0, 64'd0, 64'd0, 1'b0, 2'd2));
        send_item(trap_op(tlq_pkg::CMD_DELIVER, 2'd0, 2'd0, 3'd0, 64'd0, 64'd0, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_DELIVER, 2'd0, 2'd0, 3'd0, 64'd0, 64'd0, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_FLUSH, 2'd0, 2'd0, 3'd0, 64'd0, 64'd0, 1'b0, 2'd0));
    endtask

    task automatic test_quota_limits();
        set_quota(5'd1);
        send_item(trap_op(tlq_pkg::CMD_DECLARE, 2'd3, 2'd0, 3'd3, 64'h90, 64'h9, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_DECLARE, 2'd3, 2'd0, 3'd3, 64'hA0, 64'hA, 1'b0, 2'd0));
        set_quota(5'd0);
        send_item(trap_op(tlq_pkg::CMD_DECLARE, 2'd0, 2'd0, 3'd2, 64'hB0, 64'hB, 1'b0, 2'd0));
        send_item(trap_op(tlq_pkg::CMD_FLUSH, 2'd0, 2'd0, 3'd0, 64'd0, 64'd0, 1'b0, 2'd0));
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input logic [tlq_pkg::QUOTA_W-1:0] quota,
                                       input int count);
        logic [1:0] focus_mode;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        set_quota(quota);
        focus_mode = 2'($urandom_range(3));
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 63) begin
                focus_mode = 2'($urandom_range(3));
            end
            send_item(random_trap_op(focus_mode));
        end
    endtask

    task automatic test_output_backpressure();
        tlq_pkg::t_in_item it;
        set_quota(5'($urandom_range(5, 2)));
        long_hold_requests++;
        for (int n = 0; n < 24; n++) begin
            it = random_trap_op(2'd2);
            it.command = tlq_pkg::CMD_DECLARE;
            send_item(it);
        end
        drain();
        for (int n = 0; n < 16; n++) begin
            it = random_trap_op(2'd2);
            it.command = tlq_pkg::CMD_DELIVER;
            send_item(it);
        end
    endtask

    always @(posedge i_clk) begin
        if (long_holds_started != long_hold_requests) begin
            long_holds_started = long_hold_requests;
            stall_cycles_left  = LONG_HOLD_CYCLES;
        end
        if (stall_cycles_left > 0) begin
            stall_cycles_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (trap_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("Result with no item outstanding: %h", o_out_item);
                end
            end else begin
                due_result = trap_results_due.pop_front();
                if (o_out_item.status !== due_result.status) begin
                    note_mismatch("status", due_result.status, o_out_item.status);
                end
                if (o_out_item.out_handler_address !== due_result.out_handler_address) begin
                    note_mismatch("out_handler_address", due_result.out_handler_address,
                                  o_out_item.out_handler_address);
                end
                if (o_out_item.out_handler_param !== due_result.out_handler_param) begin
                    note_mismatch("out_handler_param", due_result.out_handler_param,
                                  o_out_item.out_handler_param);
                end
                if (o_out_item.delivered_mode !== due_result.delivered_mode) begin
                    note_mismatch("delivered_mode", due_result.delivered_mode,
                                  o_out_item.delivered_mode);
                end
                if (o_out_item.previous_enable !== due_result.previous_enable) begin
                    note_mismatch("previous_enable", due_result.previous_enable,
                                  o_out_item.previous_enable);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        reset_trap_model();
        send_idle_pct = 7;
        recv_idle_pct = 56;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_declare_checks();
        test_enables_and_delivery();
        test_flush();
        test_quota_limits();
        test_random_traffic(7, 56, 5'd31, 260);
        test_random_traffic(56, 7, 5'($urandom_range(15, 2)), 260);
        test_random_traffic(0, 0, tlq_pkg::QUOTA_RESET, 260);
        test_output_backpressure();
        drain();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && trap_results_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/tlq_pkg.sv
src/tlq_store.sv
src/tlq_ctrl.sv
src/four_level_trap_queue_core.sv
tb/sv/testbench.sv
